// ===== hdl/mtpsd_pkg.sv =====
// ============================================================================
// mtpsd_pkg: shared constants, types and tables for the multitaper PSD engine
// Holds the twiddle table, register and status codes and the divider structs.
// ============================================================================
package mtpsd_pkg;

    localparam int NFFT_MAX_DEF = 64;
    localparam int SAT48_W      = 48;
    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
    localparam logic [39:0] MAX40 = 40'hFF_FFFF_FFFF;
    localparam logic [63:0] MAX64 = 64'hFFFF_FFFF_FFFF_FFFF;

    // register indexes
    localparam logic [1:0] REG_FFT_LOG2 = 2'd0;
    localparam logic [1:0] REG_MODE     = 2'd1;
    localparam logic [1:0] REG_RATE     = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_TRUNC = 2'd1;
    localparam logic [1:0] ST_SAT = 2'd2;

    // quarter-wave sine table, signed Q3.15
    function automatic logic signed [17:0] sin_q(input logic [5:0] p);
        logic [4:0] i;
        logic [16:0] v;
        logic neg;
        begin
            neg = p[5];
            i = (p[4:0] <= 5'd16) ? p[4:0] : 5'd0;
            if (p[4:0] > 5'd16)
            begin
                i = 5'd0 - p[4:0];
                i = 5'd0 + (5'd16 - (p[4:0] - 5'd16));
            end
            case (i)
                5'd0:  v = 17'd0;
                5'd1:  v = 17'd3212;
                5'd2:  v = 17'd6393;
                5'd3:  v = 17'd9512;
                5'd4:  v = 17'd12540;
                5'd5:  v = 17'd15447;
                5'd6:  v = 17'd18205;
                5'd7:  v = 17'd20788;
                5'd8:  v = 17'd23170;
                5'd9:  v = 17'd25330;
                5'd10: v = 17'd27246;
                5'd11: v = 17'd28899;
                5'd12: v = 17'd30273;
                5'd13: v = 17'd31357;
                5'd14: v = 17'd32138;
                5'd15: v = 17'd32610;
                5'd16: v = 17'd32768;
                default: v = 17'd0;
            endcase
            sin_q = neg ? -$signed({1'b0, v}) : $signed({1'b0, v});
        end
    endfunction

    // sequencer requests to the divider
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic        edge_bin;
        logic [56:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [47:0] quo;
        logic        sat;
    } div_rsp_t;

endpackage

// ===== hdl/mtpsd_div.sv =====
// ============================================================================
// mtpsd_div: restoring divider for PSD normalization
// Computes floor(a * 2^sh / d) one quotient bit per cycle, saturating at 2^48-1.
// ============================================================================
module mtpsd_div
    import mtpsd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic        busy_reg;
    logic [6:0]  cnt_reg;
    logic [103:0] num_reg;
    logic [57:0] rem_reg;
    logic [56:0] den_reg;
    logic [47:0] quo_reg;
    logic        sat_reg;
    logic        done_reg;

    logic [57:0] shifted;
    logic        qb;
    logic [48:0] qn;

    always_comb
    begin
        shifted = {rem_reg[56:0], num_reg[103]};
        qb = shifted >= {1'b0, den_reg};
        qn = {quo_reg, qb};
    end

    // step one quotient bit a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd102;
                num_reg  <= req.edge_bin ? {1'b0, req.num, 39'd0} : {req.num, 40'd0};
                rem_reg  <= '0;
                den_reg  <= req.den;
                quo_reg  <= '0;
                sat_reg  <= 1'b0;
            end
            else if (busy_reg)
            begin
                num_reg <= {num_reg[102:0], 1'b0};
                rem_reg <= qb ? shifted - {1'b0, den_reg} : shifted;
                if (!sat_reg)
                begin
                    if (qn[48]) sat_reg <= 1'b1;
                    else quo_reg <= qn[47:0];
                end
                if (cnt_reg == 7'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg - 7'd1;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = sat_reg ? MAX48 : quo_reg;
    assign rsp.sat  = sat_reg;

endmodule

// ===== hdl/multitaper_fft_psd.sv =====
// Sequence: per bin after a row's last sample, S_KINIT, S_MACW, S_MAC and S_ROUND,
// then S_SOUT in spectrum mode or S_PWR1, S_PWR2, S_PWR3 to accumulate in PSD mode.
// PSD emission after the last taper: S_PREAD, S_DSTART, then S_DWAIT if den != 0.
// Throughput: one sample a cycle while loading a row; the DFT sequencer
// does one multiply-accumulate per cycle from the sample memory.
// Reset: asynchronous active low; registers to reset values, power bins marked empty.
module multitaper_fft_psd
    import mtpsd_pkg::*;
#(
    parameter int NFFT_MAX = NFFT_MAX_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] sample,
    input  logic signed [15:0] taper_coef,
    input  logic [15:0]        taper_weight,
    input  logic               last_sample,
    input  logic               last_taper,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [5:0]         bin_index,
    output logic signed [31:0] spectrum_real,
    output logic signed [31:0] spectrum_imag,
    output logic [47:0]        power,
    output logic [1:0]         status,
    output logic               last_bin
);

    localparam int MAXL = $clog2(NFFT_MAX);
    localparam int HALF = NFFT_MAX / 2 + 1;

    typedef enum logic [3:0] {
        S_LOAD, S_KINIT, S_MAC, S_MACW, S_ROUND, S_PWR1, S_PWR2, S_PWR3,
        S_SOUT, S_PREAD, S_DSTART, S_DWAIT, S_POUT, S_DONE
    } state_t;

    state_t      state_reg;
    logic [2:0]  lg_cfg_reg;
    logic        mode_reg;
    logic [15:0] rate_reg;
    logic [6:0]  cnt_reg;
    logic        long_reg;
    logic [39:0] wss_reg;
    logic [31:0] w2_reg;
    logic        lastt_reg;
    logic [5:0]  k_reg;
    logic [6:0]  n_reg;
    logic signed [47:0] sr_reg, si_reg;
    logic signed [31:0] re_reg, im_reg;
    logic [63:0] m_reg;
    logic [63:0] term_reg;
    logic [HALF-1:0] pv_reg;

    // sample memory and power memory
    logic signed [31:0] smem [NFFT_MAX];
    logic signed [31:0] srd_reg;
    logic [63:0] pmem [HALF];
    logic [63:0] prd_reg;
    logic [47:0] pw_reg;
    logic [1:0]  st_reg;

    // effective length
    logic [2:0] lg;
    always_comb
    begin
        lg = lg_cfg_reg;
        if (lg < 3'd2) lg = 3'd2;
        if (lg > 3'd6) lg = 3'd6;
        if (lg > 3'(MAXL)) lg = 3'(MAXL);
    end
    logic [6:0] nlen;
    logic [5:0] half;
    assign nlen = 7'd1 << lg;
    assign half = 6'(nlen >> 1);

    // tapered sample
    logic signed [31:0] prod;
    logic signed [31:0] tap;
    assign prod = sample * taper_coef;
    assign tap = (prod + 32'sd1024) >>> 11;

    // phase of the sample held in the read register, one behind n_reg
    logic [5:0] nph;
    logic [5:0] ph;
    assign nph = 6'(n_reg - 7'd1);
    assign ph = 6'((k_reg * nph) << (3'd6 - lg));
    logic signed [17:0] cw, sw;
    assign cw = sin_q(ph + 6'd16);
    assign sw = sin_q(ph);

    logic [15:0] wcl;
    logic [31:0] wsq;
    assign wcl = (taper_weight > 16'd32768) ? 16'd32768 : taper_weight;
    assign wsq = wcl * wcl;

    logic [31:0] are, aim;
    assign are = re_reg[31] ? -re_reg : re_reg;
    assign aim = im_reg[31] ? -im_reg : im_reg;

    logic [63:0] psum;
    logic [63:0] pacc;
    assign pacc = pv_reg[k_reg[MAXL-1:0]] ? prd_reg : 64'd0;
    assign psum = pacc + term_reg;

    logic [56:0] den;
    assign den = {17'd0, wss_reg} * {41'd0, rate_reg};

    div_req_t dreq;
    div_rsp_t drsp;
    assign dreq.start = state_reg == S_DSTART && den != 0;
    assign dreq.num = pacc;
    assign dreq.edge_bin = k_reg == 0 || k_reg == half;
    assign dreq.den = den;

    mtpsd_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    assign in_ready = state_reg == S_LOAD;
    assign out_valid = state_reg == S_SOUT || state_reg == S_POUT;
    assign bin_index = k_reg;
    assign spectrum_real = state_reg == S_SOUT ? re_reg : 32'sd0;
    assign spectrum_imag = state_reg == S_SOUT ? im_reg : 32'sd0;
    assign power = state_reg == S_POUT ? pw_reg : 48'd0;
    assign status = state_reg == S_POUT ? st_reg : (long_reg ? ST_TRUNC : ST_OK);
    assign last_bin = k_reg == half;

    // memories
    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOAD && in_valid && cnt_reg < nlen)
            smem[cnt_reg[MAXL-1:0]] <= tap;
        srd_reg <= (n_reg < nlen && n_reg < cnt_reg) ? smem[n_reg[MAXL-1:0]] : 32'sd0;
        prd_reg <= pmem[k_reg[MAXL-1:0]];
        if (state_reg == S_PWR3)
            pmem[k_reg[MAXL-1:0]] <= (psum < term_reg) ? MAX64 : psum;
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            lg_cfg_reg <= 3'd6;
            mode_reg <= 1'b1;
            rate_reg <= 16'd1000;
            cnt_reg <= '0;
            long_reg <= 1'b0;
            wss_reg <= '0;
            pv_reg <= '0;
            k_reg <= '0;
            n_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FFT_LOG2: lg_cfg_reg <= cfg_data[2:0];
                    REG_MODE:     mode_reg <= cfg_data[0];
                    REG_RATE:     rate_reg <= cfg_data;
                    default:      ;
                endcase
            end
            case (state_reg)
                S_LOAD:
                    if (in_valid)
                    begin
                        if (cnt_reg < nlen) cnt_reg <= cnt_reg + 7'd1;
                        else long_reg <= 1'b1;
                        if (last_sample)
                        begin
                            w2_reg <= wsq;
                            lastt_reg <= last_taper;
                            if (mode_reg)
                                wss_reg <= ({8'd0, wss_reg} + {16'd0, wsq} > {8'd0, MAX40})
                                    ? MAX40 : wss_reg + {8'd0, wsq};
                            k_reg <= '0;
                            state_reg <= S_KINIT;
                        end
                    end
                S_KINIT:
                begin
                    n_reg <= '0;
                    sr_reg <= '0;
                    si_reg <= '0;
                    state_reg <= S_MACW;
                end
                S_MACW:
                begin
                    n_reg <= n_reg + 7'd1;
                    state_reg <= S_MAC;
                end
                S_MAC:
                begin
                    sr_reg <= sr_reg + srd_reg * cw;
                    si_reg <= si_reg - srd_reg * sw;
                    if (n_reg == nlen) state_reg <= S_ROUND;
                    else n_reg <= n_reg + 7'd1;
                end
                S_ROUND:
                begin
                    re_reg <= 32'((sr_reg + 48'sd16384) >>> 15);
                    im_reg <= 32'((si_reg + 48'sd16384) >>> 15);
                    state_reg <= mode_reg ? S_PWR1 : S_SOUT;
                end
                S_PWR1:
                begin
                    m_reg <= are * are + aim * aim;
                    state_reg <= S_PWR2;
                end
                S_PWR2:
                begin
                    term_reg <= ((m_reg >> 32) * w2_reg << 2)
                        + (((m_reg & 64'hFFFF_FFFF) * w2_reg) >> 30);
                    state_reg <= S_PWR3;
                end
                S_PWR3:
                begin
                    pv_reg[k_reg[MAXL-1:0]] <= 1'b1;
                    if (k_reg == half)
                    begin
                        k_reg <= '0;
                        if (lastt_reg) state_reg <= S_PREAD;
                        else state_reg <= S_DONE;
                    end
                    else
                    begin
                        k_reg <= k_reg + 6'd1;
                        state_reg <= S_KINIT;
                    end
                end
                S_SOUT:
                    if (out_ready)
                    begin
                        if (k_reg == half)
                        begin
                            long_reg <= 1'b0;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            k_reg <= k_reg + 6'd1;
                            state_reg <= S_KINIT;
                        end
                    end
                // wait for the power memory read of the new bin
                S_PREAD:
                    state_reg <= S_DSTART;
                S_DSTART:
                begin
                    if (den == 0)
                    begin
                        pw_reg <= pacc != 0 ? MAX48 : 48'd0;
                        st_reg <= pacc != 0 ? ST_SAT : (long_reg ? ST_TRUNC : ST_OK);
                        state_reg <= S_POUT;
                    end
                    else state_reg <= S_DWAIT;
                end
                S_DWAIT:
                    if (drsp.done)
                    begin
                        pw_reg <= drsp.quo;
                        st_reg <= drsp.sat ? ST_SAT : (long_reg ? ST_TRUNC : ST_OK);
                        state_reg <= S_POUT;
                    end
                S_POUT:
                    if (out_ready)
                    begin
                        if (k_reg == half)
                        begin
                            long_reg <= 1'b0;
                            wss_reg <= '0;
                            pv_reg <= '0;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            k_reg <= k_reg + 6'd1;
                            state_reg <= S_PREAD;
                        end
                    end
                S_DONE:
                begin
                    cnt_reg <= '0;
                    k_reg <= '0;
                    state_reg <= S_LOAD;
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

endmodule

// ===== hdl/mtpsd_check.sv =====
// ============================================================================
// mtpsd_check: port-level checks for the multitaper PSD engine
// Watches handshakes and result fields of the top level.
// ============================================================================
module mtpsd_check
    import mtpsd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [47:0] power
);

    // hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(power))
        else $error("result dropped while stalled");

    // never take input while presenting a result
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready during output");

    // status code in range
    a_st: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3)
        else $error("bad status");

endmodule

bind multitaper_fft_psd mtpsd_check u_check (.clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .out_valid(out_valid),
    .out_ready(out_ready), .status(status), .power(power));
